// ----- hdl/json_token_lexer_macros.svh -----
// Assertion macros shared by the lexer checker.
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define JTL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lexer check failed");

// Next-cycle implication, ignored while reset is high.
`define JTL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lexer check failed");

// Next-cycle implication that also holds across reset.
`define JTL_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

// ----- hdl/jtl_pkg.sv -----
// Types, constants and lookup functions of the token lexer.
package jtl_pkg;

   localparam int NumBits = 31;
   localparam int CharW   = 8;
   localparam int KindW   = 5;
   localparam int ValueW  = 31;
   localparam int QPtrW   = 3;
   localparam int QDepth  = 1 << QPtrW;
   localparam int QLvlW   = QPtrW + 1;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_IDENT = 2'd1,
      MODE_NUM   = 2'd2
   } mode_type;

   typedef enum logic [KindW-1:0] {
      K_ICHAR  = 5'd0,
      K_IEND   = 5'd1,
      K_NUM    = 5'd2,
      K_PLUS   = 5'd3,
      K_MINUS  = 5'd4,
      K_STAR   = 5'd5,
      K_SLASH  = 5'd6,
      K_LBRACE = 5'd7,
      K_RBRACE = 5'd8,
      K_LBRACK = 5'd9,
      K_RBRACK = 5'd10,
      K_LPAREN = 5'd11,
      K_RPAREN = 5'd12,
      K_DOT    = 5'd13,
      K_COMMA  = 5'd14,
      K_QUOTE  = 5'd15,
      K_COLON  = 5'd16,
      K_END    = 5'd17,
      K_ERR    = 5'd18
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CharW-1:0]    ichar;
      logic [ValueW-1:0]   value;
      logic                ovf;
   } token_type;

   // Up to two tokens produced by one byte, in order.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   // Punctuation code of a byte, error code for anything else.
   function automatic kind_type punct_kind(input logic [CharW-1:0] c);
      kind_type k;
      unique case (c)
         8'h2B:   k = K_PLUS;
         8'h2D:   k = K_MINUS;
         8'h2A:   k = K_STAR;
         8'h2F:   k = K_SLASH;
         8'h7B:   k = K_LBRACE;
         8'h7D:   k = K_RBRACE;
         8'h5B:   k = K_LBRACK;
         8'h5D:   k = K_RBRACK;
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h2E:   k = K_DOT;
         8'h2C:   k = K_COMMA;
         8'h22:   k = K_QUOTE;
         8'h3A:   k = K_COLON;
         default: k = K_ERR;
      endcase
      return k;
   endfunction

endpackage

// ----- hdl/json_token_lexer.sv -----
// An accepted byte is registered in the input stage and decoded; its tokens queue until taken.
// Throughput: one input word per cycle while results drain at one word per cycle;
//   a byte closing a token can yield two result words, and input stalls above four queued tokens.
// Rate limit: single result port draining an eight-entry token queue.
// Reset: synchronous, active high; clears mode, number, queue and input stage.
module json_token_lexer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol_byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] ident_char, [38:8] number_value,
                                    // [39] number_overflow
   output logic [4:0]  rsp_tuser    // [4:0] token_kind
);
   import jtl_pkg::*;

   push_type            push;
   token_type           head;
   logic                head_valid;
   logic [QLvlW-1:0]    level;
   logic                req_take;

   // Admit a word only while the queue can absorb both the word in the
   // input stage and this one, two tokens each in the worst case.
   assign req_tready = (level <= QLvlW'(QDepth - 4));
   assign req_take   = req_tvalid && req_tready;

   // Register the byte, decode it against the mode and push its tokens.
   jtl_lex u_lex (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_take),
      .in_byte  (req_tdata),
      .push     (push)
   );

   // Hold tokens until the consumer takes them; advance on each handshake.
   jtl_tokq u_tokq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head       (head),
      .head_valid (head_valid),
      .level      (level)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {head.ovf, head.value, head.ichar};
   assign rsp_tuser  = head.kind;

endmodule

// ----- hdl/jtl_lex.sv -----
// Input register, lexer state and token decode for one byte per cycle.
module jtl_lex (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [jtl_pkg::CharW-1:0] in_byte,
   output jtl_pkg::push_type         push
);
   import jtl_pkg::*;

   logic                byte_vld_ff;
   logic [CharW-1:0]    byte_ff;
   mode_type            mode_ff, mode_in;
   logic [NumBits-1:0]  acc_ff, acc_in;
   logic                ovf_ff, ovf_in;

   logic is_end, is_letter, is_digit, is_under, is_space, is_zero;
   logic stay_ident, stay_num, close_ident, close_num;
   logic [NumBits+3:0] acc_ext, acc_mul, max_ext;
   logic               sat;
   logic [NumBits-1:0] digit_val;
   token_type          fresh_tok, char_tok, num_tok, iend_tok;
   logic               fresh_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         byte_vld_ff <= in_valid;
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         byte_ff <= in_byte;
      end
   end

   // Character classes.
   always_comb begin
      is_end    = (byte_ff == 8'h00) || (byte_ff == 8'hFF);
      is_letter = ((byte_ff >= 8'h41) && (byte_ff <= 8'h5A)) ||
                  ((byte_ff >= 8'h61) && (byte_ff <= 8'h7A));
      is_digit  = (byte_ff >= 8'h30) && (byte_ff <= 8'h39);
      is_zero   = (byte_ff == 8'h30);
      is_under  = (byte_ff == 8'h5F);
      is_space  = (byte_ff <= 8'h20) || (byte_ff >= 8'h80);
      digit_val = NumBits'(byte_ff[3:0]);
   end

   // Mode decode; the unused mode code acts as idle.
   always_comb begin
      stay_ident  = 1'b0;
      stay_num    = 1'b0;
      close_ident = 1'b0;
      close_num   = 1'b0;
      unique case (mode_ff)
         MODE_IDENT: begin
            stay_ident  = !is_end && (is_letter || is_digit || is_under);
            close_ident = !stay_ident;
         end
         MODE_NUM: begin
            stay_num  = !is_end && is_digit;
            close_num = !stay_num;
         end
         default: begin
         end
      endcase
   end

   // acc * 10 + digit, saturating at the all-ones value.
   always_comb begin
      acc_ext = (NumBits+4)'(acc_ff);
      acc_mul = (acc_ext << 3) + (acc_ext << 1) + (NumBits+4)'(digit_val);
      max_ext = {4'b0000, {NumBits{1'b1}}};
      sat     = acc_mul > max_ext;
   end

   // Next state.
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      if (byte_vld_ff) begin
         if (stay_num) begin
            acc_in = sat ? {NumBits{1'b1}} : acc_mul[NumBits-1:0];
            ovf_in = ovf_ff | sat;
         end else if (!stay_ident) begin
            mode_in = MODE_IDLE;
            if (close_num) begin
               acc_in = '0;
               ovf_in = 1'b0;
            end
            if (!is_end && is_letter) begin
               mode_in = MODE_IDENT;
            end else if (!is_end && is_digit && !is_zero) begin
               mode_in = MODE_NUM;
               acc_in  = digit_val;
               ovf_in  = 1'b0;
            end
         end
      end
   end

   // Tokens.
   always_comb begin
      char_tok       = '0;
      char_tok.kind  = K_ICHAR;
      char_tok.ichar = byte_ff;
      iend_tok       = '0;
      iend_tok.kind  = K_IEND;
      num_tok        = '0;
      num_tok.kind   = K_NUM;
      num_tok.value  = ValueW'(acc_ff);
      num_tok.ovf    = ovf_ff;

      fresh_tok  = '0;
      fresh_emit = 1'b1;
      priority if (is_end) begin
         fresh_tok.kind = K_END;
      end else if (is_letter) begin
         fresh_tok = char_tok;
      end else if (is_zero) begin
         fresh_tok.kind = K_NUM;
      end else if (is_digit || is_space) begin
         fresh_emit = 1'b0;
      end else begin
         fresh_tok.kind = punct_kind(byte_ff);
      end

      push = '0;
      if (byte_vld_ff) begin
         priority if (stay_ident) begin
            push.count = 2'd1;
            push.tok0  = char_tok;
         end else if (stay_num) begin
            push.count = 2'd0;
         end else if (close_ident || close_num) begin
            push.tok0  = close_ident ? iend_tok : num_tok;
            push.tok1  = fresh_tok;
            push.count = fresh_emit ? 2'd2 : 2'd1;
         end else begin
            push.tok0  = fresh_tok;
            push.count = {1'b0, fresh_emit};
         end
      end
   end

endmodule

// ----- hdl/jtl_tokq.sv -----
// Small token queue that takes up to two tokens and gives one per cycle.
module jtl_tokq (
   input  logic                      clock,
   input  logic                      reset,
   input  jtl_pkg::push_type         push,
   input  logic                      pop,
   output jtl_pkg::token_type        head,
   output logic                      head_valid,
   output logic [jtl_pkg::QLvlW-1:0] level
);
   import jtl_pkg::*;

   token_type          q_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLvlW-1:0]   level_ff, level_in;
   logic               do_pop;

   always_comb begin
      do_pop    = pop && (level_ff != '0);
      wr_ptr_in = wr_ptr_ff + QPtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + QPtrW'(do_pop);
      level_in  = level_ff + QLvlW'(push.count) - QLvlW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_ptr_ff + QPtrW'(1)] <= push.tok1;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (level_ff != '0);
   assign level      = level_ff;

endmodule

// ----- hdl/jtl_checker.sv -----
// Port-level checks of the token lexer, bound to the top level.
`include "json_token_lexer_macros.svh"

module jtl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [4:0]  rsp_tuser
);
   import jtl_pkg::*;

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata);

   `JTL_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)
   `JTL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `JTL_ASSERT_NOW(a_char_only_ident, rsp_tvalid && (rsp_tuser != K_ICHAR), rsp_tdata[7:0] == 8'h00)
   `JTL_ASSERT_NOW(a_num_fields, rsp_tvalid && (rsp_tuser != K_NUM), rsp_tdata[39:8] == 32'h0)

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (.*);

// ----- verif/json_token_lexer_checker.sv -----
// Token checker for the lexer: mirrors the byte scanner and compares every result word.
`timescale 1ns / 1ps
module json_token_lexer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [7:0] ident_char, [38:8] number_value,
                                    // [39] number_overflow
   input  logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output int          fail_count,
   output int          tokens_pending
);
   import jtl_pkg::*;

   localparam longint unsigned NumMax = (64'd1 << NumBits) - 64'd1;

   token_type        token_fifo[$];
   mode_type         scan_mode;
   longint unsigned  num_acc;
   logic             num_ovf;

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic queue_token(kind_type k, logic [7:0] ch, logic [30:0] v, logic o);
      token_type t;
      t.kind  = k;
      t.ichar = ch;
      t.value = v;
      t.ovf   = o;
      token_fifo.push_back(t);
   endtask

   task automatic scan_byte(logic [7:0] c);
      bit              at_end;
      longint unsigned d;
      kind_type        k;
      at_end = (c == 8'h00) || (c == 8'hFF);
      d      = longint'(c) - 48;
      // close or extend the pending token
      case (scan_mode)
         MODE_IDENT: begin
            if (!at_end && (is_alpha(c) || is_numeral(c) || c == "_")) begin
               queue_token(K_ICHAR, c, '0, 1'b0);
               return;
            end
            queue_token(K_IEND, '0, '0, 1'b0);
            scan_mode = MODE_IDLE;
         end
         MODE_NUM: begin
            if (!at_end && is_numeral(c)) begin
               if (num_acc > (NumMax - d) / 10) begin
                  num_acc = NumMax;
                  num_ovf = 1'b1;
               end else begin
                  num_acc = num_acc * 10 + d;
               end
               return;
            end
            queue_token(K_NUM, '0, num_acc[30:0], num_ovf);
            scan_mode = MODE_IDLE;
            num_acc   = 0;
            num_ovf   = 1'b0;
         end
         default: begin
            scan_mode = MODE_IDLE;
         end
      endcase
      if (at_end) begin
         queue_token(K_END, '0, '0, 1'b0);
         return;
      end
      // fresh byte in idle mode
      if (is_alpha(c)) begin
         scan_mode = MODE_IDENT;
         queue_token(K_ICHAR, c, '0, 1'b0);
      end else if (c == "0") begin
         queue_token(K_NUM, '0, '0, 1'b0);
      end else if (is_numeral(c)) begin
         scan_mode = MODE_NUM;
         num_acc   = d;
         num_ovf   = 1'b0;
      end else if (c > 8'h20 && c < 8'h80) begin
         case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            ".":     k = K_DOT;
            ",":     k = K_COMMA;
            "\"":    k = K_QUOTE;
            ":":     k = K_COLON;
            default: k = K_ERR;
         endcase
         queue_token(k, '0, '0, 1'b0);
      end
   endtask

   always @(posedge clock) begin
      token_type due;
      int        errs;
      errs = 0;
      if (reset) begin
         scan_mode = MODE_IDLE;
         num_acc   = 0;
         num_ovf   = 1'b0;
         token_fifo.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (token_fifo.size() == 0) begin
               $error("token_kind: no word expected, actual %0d", rsp_tuser);
               errs++;
            end else begin
               due = token_fifo.pop_front();
               if (rsp_tuser !== due.kind) begin
                  $error("token_kind: expected %0d, actual %0d", due.kind, rsp_tuser);
                  errs++;
               end
               if (rsp_tdata[7:0] !== due.ichar) begin
                  $error("ident_char: expected %0h, actual %0h", due.ichar, rsp_tdata[7:0]);
                  errs++;
               end
               if (rsp_tdata[38:8] !== due.value) begin
                  $error("number_value: expected %0d, actual %0d", due.value,
                         rsp_tdata[38:8]);
                  errs++;
               end
               if (rsp_tdata[39] !== due.ovf) begin
                  $error("number_overflow: expected %0b, actual %0b", due.ovf,
                         rsp_tdata[39]);
                  errs++;
               end
            end
         end
      end
      fail_count     <= fail_count + errs;
      tokens_pending <= token_fifo.size();
   end

endmodule

// ----- verif/json_token_lexer_test.sv -----
// Top of the lexer regression: clock, reset, byte stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module json_token_lexer_test;

   // Longest stretch without any accepted word before the run is called hung.
   localparam int StallLimit   = 2000;
   // Target count of random bytes after the directed part.
   localparam int RandomBytes  = 1950;
   // Bytes at the tail of the stream sent with no idling on either side.
   localparam int CalmTail     = 200;
   // Long receiver hold-off that fills the token queue and stalls the input.
   localparam int SqueezeLen   = 150;
   localparam int SqueezeAfter = 400;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] symbol_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [7:0] ident_char, [38:8] number_value,
                                      // [39] number_overflow
   logic [4:0]  rsp_tuser;            // [4:0] token_kind

   int          fail_count;
   int          tokens_pending;
   int          idle_cycles;

   logic [7:0]  byte_stream[$];
   int          bytes_sent   = 0;
   bit          calm         = 1'b0;
   bit          squeeze      = 1'b0;
   bit          squeeze_done = 1'b0;

   json_token_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   json_token_lexer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Append the characters of a string to the byte stream.
   task automatic push_text(string s);
      foreach (s[i]) byte_stream.push_back(s[i]);
   endtask

   // Fill the byte stream: a short directed opening, then random token-shaped text.
   task automatic build_stream();
      string letters;
      string punct;
      int    len;
      int    pick;
      int    shape;
      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
      punct   = "+-*/{}[]().,\":";

      // identifier with digit and underscore inside, closed by punctuation
      push_text("a_9(");
      // leading zero gives an immediate zero, then 7 starts a number closed by ')'
      push_text("07)");
      // underscore in idle mode and unknown bytes are errors
      push_text("_#");
      byte_stream.push_back(8'h7F);
      // whitespace from both ranges, newline and space included
      byte_stream.push_back(8'h20);
      byte_stream.push_back(8'h0A);
      byte_stream.push_back(8'h80);
      byte_stream.push_back(8'hFE);
      // saturating number flushed by the 0xFF end marker
      push_text("9999999999");
      byte_stream.push_back(8'hFF);
      // pending identifier flushed by the zero end marker
      push_text("z");
      byte_stream.push_back(8'h00);

      while (byte_stream.size() < RandomBytes + 27) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // identifier: letter first, then letters, digits and underscores
            len = $urandom_range(1, 8);
            byte_stream.push_back(letters[$urandom_range(0, 51)]);
            repeat (len - 1) begin
               case ($urandom_range(0, 3))
                  0:       byte_stream.push_back(8'(8'h30 + $urandom_range(0, 9)));
                  1:       byte_stream.push_back("_");
                  default: byte_stream.push_back(letters[$urandom_range(0, 51)]);
               endcase
            end
         end else if (pick < 45) begin
            // number: mostly short, sometimes long enough to saturate or right at the edge
            shape = $urandom_range(0, 15);
            len   = 1;
            case (shape)
               0:       push_text("2147483647");
               1:       push_text("2147483648");
               2, 3:    len = $urandom_range(10, 14);
               default: len = $urandom_range(1, 6);
            endcase
            if (shape > 1) begin
               byte_stream.push_back(8'(8'h31 + $urandom_range(0, 8)));
               repeat (len - 1) byte_stream.push_back(8'(8'h30 + $urandom_range(0, 9)));
            end
         end else if (pick < 65) begin
            byte_stream.push_back(punct[$urandom_range(0, 13)]);
         end else if (pick < 75) begin
            case ($urandom_range(0, 3))
               0:       byte_stream.push_back(8'h20);
               1:       byte_stream.push_back(8'h0A);
               2:       byte_stream.push_back(8'($urandom_range(8'h01, 8'h20)));
               default: byte_stream.push_back(8'($urandom_range(8'h80, 8'hFE)));
            endcase
         end else if (pick < 80) begin
            byte_stream.push_back("0");
         end else if (pick < 85) begin
            byte_stream.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
         end else begin
            // noise: any byte at all
            byte_stream.push_back(8'($urandom_range(0, 255)));
         end
         // separate tokens with a space half of the time
         if ($urandom_range(0, 1) == 0) byte_stream.push_back(8'h20);
      end
   endtask

   // Sender: offer each byte in turn, idling in random bursts until the calm tail.
   initial begin
      build_stream();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (byte_stream[i]) begin
         if (!calm && !squeeze && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= byte_stream[i];
         do @(posedge clock); while (!req_tready);
         bytes_sent++;
         if (bytes_sent >= byte_stream.size() - CalmTail) calm = 1'b1;
      end
      req_tvalid <= 1'b0;
      // drain every expected word, then allow for the pipeline latency
      do @(posedge clock); while (tokens_pending != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver: ready in random stretches, stall in bursts, and hold off once for long.
   initial begin
      forever begin
         if (!squeeze_done && bytes_sent >= SqueezeAfter) begin
            squeeze    = 1'b1;
            rsp_tready <= 1'b0;
            repeat (SqueezeLen) @(posedge clock);
            squeeze      = 1'b0;
            squeeze_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Watchdog: count cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
